FILE: design/coap_option_decoder_unit_defines.svh
// assertion helpers for the decoder top level
`ifndef COAP_OPTION_DECODER_UNIT_DEFINES_SVH
`define COAP_OPTION_DECODER_UNIT_DEFINES_SVH

// clocked check, muted while reset is asserted
`define COAPOD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication, same cycle
`define COAPOD_ASSERT_IMP(label, ante, cons, msg) \
	`COAPOD_ASSERT(label, (ante) |-> (cons), msg)

// clocked implication, next cycle
`define COAPOD_ASSERT_NXT(label, ante, cons, msg) \
	`COAPOD_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: design/coapod_pkg.sv
package coapod_pkg;

	localparam int INT_BYTES_DEF = 4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RESERVED  = 3'd1;
	localparam logic [2:0] ST_HDR_OVER  = 3'd2;
	localparam logic [2:0] ST_EXT_OVFL  = 3'd3;
	localparam logic [2:0] ST_OPT_OVER  = 3'd4;

	// nibble codes
	localparam logic [3:0] NIB_EXT8     = 4'd13;
	localparam logic [3:0] NIB_EXT16    = 4'd14;
	localparam logic [3:0] NIB_RESERVED = 4'd15;

	localparam logic [15:0] EXT8_BASE       = 16'd13;
	localparam logic [15:0] EXT16_BASE      = 16'd269;
	localparam logic [15:0] EXT16_RAW_LIMIT = 16'd65266;

	// block option fields
	localparam int         BLOCK_VALUE_BITS = 24;
	localparam int         BLOCK_MORE_BIT   = 3;
	localparam logic [2:0] BLOCK_SZX_MAX    = 3'h7;
	localparam logic [11:0] BLOCK_SIZE_MIN  = 12'd16;

	localparam int OUT_BITS  = 105;
	localparam int OUT_TDATA = 112;

	// decoded header of one option, as handed from the parser
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] option_delta;
		logic [15:0] content_length;
		logic [2:0]  header_bytes;
	} coapod_hdr_t;

	// full result word, fields declared from the top of the output bus down to bit 0
	typedef struct packed {
		logic        block_ok;
		logic [11:0] block_size;
		logic        block_more;
		logic [19:0] block_number;
		logic        int_ok;
		logic [31:0] int_value;
		logic [2:0]  header_bytes;
		logic [15:0] content_length;
		logic [15:0] option_delta;
		logic [2:0]  status;
	} coapod_res_t;

	// extension bytes that follow a nibble
	function automatic logic [1:0] ext_size(input logic [3:0] nib);
		logic [1:0] r;
		r = 2'd0;
		if (nib == NIB_EXT8)  r = 2'd1;
		if (nib == NIB_EXT16) r = 2'd2;
		return r;
	endfunction

endpackage

FILE: design/coapod_parser.sv
module coapod_parser
	import coapod_pkg::*;
#(
	parameter int INT_BYTES = INT_BYTES_DEF,
	localparam int ACC_W = 8 * INT_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        data_byte,
	input  logic              first_byte,
	input  logic [15:0]       max_bytes,
	output logic              res_valid,
	output coapod_hdr_t       res_hdr,
	output logic [ACC_W-1:0]  res_value
);

	typedef enum logic [1:0] {PH_IDLE, PH_DELTA_EXT, PH_LEN_EXT, PH_VALUE} phase_t;

	phase_t           phase_q, n_phase;
	logic [3:0]       dnib_q, n_dnib, lnib_q, n_lnib;
	logic [1:0]       ext_q, n_ext;
	logic [15:0]      dacc_q, n_dacc, lacc_q, n_lacc;
	logic [15:0]      left_q, n_left, budget_q, n_budget;
	logic [ACC_W-1:0] vacc_q, n_vacc;
	logic [2:0]       hdr_q, n_hdr;

	logic        go_delta, go_len, err, ok, is_d, ext_done;
	logic [2:0]  code;
	logic [3:0]  nib;
	logic [15:0] acc, acc_n, raw;

	always_comb begin
		n_phase  = phase_q;
		n_dnib   = dnib_q;
		n_lnib   = lnib_q;
		n_ext    = ext_q;
		n_dacc   = dacc_q;
		n_lacc   = lacc_q;
		n_left   = left_q;
		n_budget = budget_q;
		n_vacc   = vacc_q;
		n_hdr    = hdr_q;
		go_delta = 1'b0;
		go_len   = 1'b0;
		err      = 1'b0;
		ok       = 1'b0;
		code     = ST_OK;
		is_d     = (phase_q == PH_DELTA_EXT);
		nib      = is_d ? dnib_q : lnib_q;
		acc      = is_d ? dacc_q : lacc_q;
		acc_n    = acc;
		raw      = {acc[15:8], data_byte};
		ext_done = 1'b0;

		if (first_byte) begin
			n_budget = max_bytes;
			n_dnib   = data_byte[7:4];
			n_lnib   = data_byte[3:0];
			n_hdr    = 3'd1;
			n_dacc   = '0;
			n_lacc   = '0;
			n_vacc   = '0;
			n_left   = '0;
			n_ext    = '0;
			if (max_bytes == 16'd0) begin
				err  = 1'b1;
				code = ST_HDR_OVER;
			end else if (n_dnib == NIB_RESERVED) begin
				err  = 1'b1;
				code = ST_RESERVED;
			end else if (16'(ext_size(n_dnib)) + 16'd1 > max_bytes) begin
				err  = 1'b1;
				code = ST_HDR_OVER;
			end else if (ext_size(n_dnib) != 2'd0) begin
				n_phase = PH_DELTA_EXT;
				n_ext   = ext_size(n_dnib);
			end else begin
				n_dacc   = {12'd0, n_dnib};
				go_delta = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_DELTA_EXT, PH_LEN_EXT: begin
					n_hdr = 3'(hdr_q + 3'd1);
					if (nib == NIB_EXT8) begin
						acc_n    = 16'(data_byte) + EXT8_BASE;
						ext_done = 1'b1;
					end else if (ext_q == 2'd2) begin
						// high byte of a two-byte extension
						acc_n = {data_byte, 8'd0};
						n_ext = 2'd1;
					end else if (raw > EXT16_RAW_LIMIT) begin
						err  = 1'b1;
						code = ST_EXT_OVFL;
					end else begin
						acc_n    = raw + EXT16_BASE;
						ext_done = 1'b1;
					end
					if (is_d) n_dacc = acc_n;
					else n_lacc = acc_n;
					if (ext_done) begin
						n_ext    = 2'd0;
						go_delta = is_d;
						go_len   = !is_d;
					end
				end
				PH_VALUE: begin
					if (lacc_q <= 16'(INT_BYTES)) n_vacc = ACC_W'({vacc_q, data_byte});
					if (left_q != 16'd0) n_left = left_q - 16'd1;
					if (n_left == 16'd0) ok = 1'b1;
				end
				default: ;
			endcase
		end

		// delta settled: check the length nibble and the header size
		if (go_delta) begin
			if (n_lnib == NIB_RESERVED) begin
				err  = 1'b1;
				code = ST_RESERVED;
			end else if (16'(ext_size(n_dnib)) + 16'(ext_size(n_lnib)) + 16'd1 > n_budget) begin
				err  = 1'b1;
				code = ST_HDR_OVER;
			end else if (ext_size(n_lnib) != 2'd0) begin
				n_phase = PH_LEN_EXT;
				n_ext   = ext_size(n_lnib);
				n_lacc  = '0;
			end else begin
				n_lacc = {12'd0, n_lnib};
				go_len = 1'b1;
			end
		end

		// length settled: check the whole option against the budget
		if (go_len) begin
			if (17'(n_hdr) + 17'(n_lacc) > 17'(n_budget)) begin
				err  = 1'b1;
				code = ST_OPT_OVER;
			end else begin
				n_left = n_lacc;
				n_vacc = '0;
				if (n_lacc == 16'd0) ok = 1'b1;
				else n_phase = PH_VALUE;
			end
		end

		if (err || ok) n_phase = PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			dnib_q   <= '0;
			lnib_q   <= '0;
			ext_q    <= '0;
			dacc_q   <= '0;
			lacc_q   <= '0;
			left_q   <= '0;
			budget_q <= '0;
			vacc_q   <= '0;
			hdr_q    <= '0;
		end else if (step_en) begin
			phase_q  <= n_phase;
			dnib_q   <= n_dnib;
			lnib_q   <= n_lnib;
			ext_q    <= n_ext;
			dacc_q   <= n_dacc;
			lacc_q   <= n_lacc;
			left_q   <= n_left;
			budget_q <= n_budget;
			vacc_q   <= n_vacc;
			hdr_q    <= n_hdr;
		end
	end

	// an error result carries only its code
	assign res_valid              = step_en && (err || ok);
	assign res_hdr.status         = err ? code : ST_OK;
	assign res_hdr.option_delta   = err ? 16'd0 : n_dacc;
	assign res_hdr.content_length = err ? 16'd0 : n_lacc;
	assign res_hdr.header_bytes   = err ? 3'd0 : n_hdr;
	assign res_value              = err ? '0 : n_vacc;

endmodule

FILE: design/coapod_result.sv
module coapod_result
	import coapod_pkg::*;
#(
	parameter int INT_BYTES = INT_BYTES_DEF,
	localparam int ACC_W = 8 * INT_BYTES
) (
	input  coapod_hdr_t      hdr,
	input  logic [ACC_W-1:0] value,
	output coapod_res_t      res
);

	logic        iok, good;
	logic [63:0] v;

	assign good = (hdr.status == ST_OK);
	assign iok  = good && (hdr.content_length <= 16'(INT_BYTES));
	assign v    = iok ? 64'(value) : 64'd0;

	always_comb begin
		res                = '0;
		res.status         = hdr.status;
		res.option_delta   = hdr.option_delta;
		res.content_length = hdr.content_length;
		res.header_bytes   = hdr.header_bytes;
		if (good) begin
			res.int_value    = v[31:0];
			res.int_ok       = iok;
			res.block_number = v[23:4];
			res.block_more   = v[BLOCK_MORE_BIT];
			res.block_size   = BLOCK_SIZE_MIN << v[2:0];
			// szx 7 would mean 2048, beyond the largest legal block
			res.block_ok     = iok && (v[63:BLOCK_VALUE_BITS] == '0)
				&& (v[2:0] != BLOCK_SZX_MAX);
		end
	end

endmodule

FILE: design/coap_option_decoder_unit.sv
// decoder for the header and value of one coap option, fed one byte per word on
// s_axis. a word with tuser high opens an option and brings its byte budget in
// tdata; the delta and length nibbles with their one- and two-byte extensions
// are decoded, the value is gathered big-endian when it is at most INT_BYTES
// long, and block option fields are derived from it. one result word leaves
// on m_axis when the last value byte is in, when the header ends with an empty
// value, or as soon as an error shows up; bytes after an error or outside an
// option are dropped until the next start. a byte is taken every clock with
// no bubbles, and a result leaves through the input register and then the
// result register after its last byte; the only stall is m_axis backpressure
// reaching the input stage while the result register is full
module coap_option_decoder_unit
	import coapod_pkg::*;
#(
	parameter int INT_BYTES = INT_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // data_byte, max_bytes
	input  logic                 s_axis_tuser,  // first_byte
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// status, option_delta, content_length, header_bytes, int_value, int_ok,
	// block_number, block_more, block_size, block_ok, zero pad
	output logic [OUT_TDATA-1:0] m_axis_tdata
);

	`include "coap_option_decoder_unit_defines.svh"

	localparam int ACC_W = 8 * INT_BYTES;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [15:0] budget_s1;

	// output stage
	logic        out_valid_q;
	coapod_res_t out_res_q;

	logic             advance;
	logic             res_valid;
	coapod_hdr_t      res_hdr;
	logic [ACC_W-1:0] res_value;
	coapod_res_t      res;

	// the input stage moves on unless a result is stuck in the output register
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1   <= s_axis_tdata[7:0];
			budget_s1 <= s_axis_tdata[23:8];
			first_s1  <= s_axis_tuser;
		end
	end

	coapod_parser #(
		.INT_BYTES (INT_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.data_byte  (byte_s1),
		.first_byte (first_s1),
		.max_bytes  (budget_s1),
		.res_valid  (res_valid),
		.res_hdr    (res_hdr),
		.res_value  (res_value)
	);

	coapod_result #(
		.INT_BYTES (INT_BYTES)
	) u_result (
		.hdr   (res_hdr),
		.value (res_value),
		.res   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA'(out_res_q);

	`COAPOD_ASSERT_IMP(a_err_clean, out_valid_q && (out_res_q.status != ST_OK),
		(out_res_q.option_delta == 16'd0) && (out_res_q.int_value == 32'd0)
		&& (out_res_q.block_size == 12'd0), "error word carries non-zero fields")
	`COAPOD_ASSERT_IMP(a_ok_hdr, out_valid_q && (out_res_q.status == ST_OK),
		(out_res_q.header_bytes >= 3'd1) && (out_res_q.header_bytes <= 3'd5),
		"header byte count out of range")
	`COAPOD_ASSERT_IMP(a_block_int, out_valid_q && out_res_q.block_ok,
		out_res_q.int_ok, "block_ok without int_ok")
	`COAPOD_ASSERT_NXT(a_hold_s1, valid_s1 && !advance, valid_s1,
		"input stage dropped a stalled byte")
	`COAPOD_ASSERT_IMP(a_no_overrun, res_valid, !out_valid_q || m_axis_tready,
		"result overwrote a pending word")

endmodule

FILE: tb/testbench.sv
// checks the coap option decoder against a cycle-free model of the option
// parser: every accepted byte is run through the model, every result word the
// model predicts is queued, and each word leaving m_axis is compared field by
// field against the oldest queued expectation
module testbench
	import coapod_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 345;
	localparam int STALL_LIMIT  = 2000;
	localparam int WHOLE        = 65536;   // send every byte of an option
	localparam int DRAIN_CYCLES = 8;       // a result passes the input and result registers after its byte

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // data_byte, max_bytes
	logic        s_axis_tuser  = 1'b0; // first_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// status, option_delta, content_length, header_bytes, int_value, int_ok,
	// block_number, block_more, block_size, block_ok, zero pad
	logic [OUT_TDATA-1:0] m_axis_tdata;

	// idle percentages for the sending and the receiving side
	int send_idle_pct  = 33;
	int recv_stall_pct = 48;

	int items_sent   = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	coapod_res_t decoded_words[$];

	// parser state of the model
	typedef enum logic [1:0] {
		DEC_IDLE,
		DEC_DELTA_EXT,
		DEC_LEN_EXT,
		DEC_VALUE
	} dec_phase_t;

	dec_phase_t  dec_phase      = DEC_IDLE;
	logic [3:0]  dec_dnib       = '0;
	logic [3:0]  dec_lnib       = '0;
	logic [1:0]  dec_ext_left   = '0;
	logic [15:0] dec_delta      = '0;
	logic [15:0] dec_len        = '0;
	logic [15:0] dec_value_left = '0;
	logic [31:0] dec_value      = '0;
	logic [15:0] dec_budget     = '0;
	logic [2:0]  dec_hdr_cnt    = '0;

	coap_option_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// option parser model
	// ---------------------------------------------------------------------

	// extension bytes that follow a delta or length nibble
	function automatic int ext_bytes_for(logic [3:0] nib);
		if (nib == NIB_EXT8)
			return 1;
		if (nib == NIB_EXT16)
			return 2;
		return 0;
	endfunction

	// error word: only the status is set, the parser drops the option
	function automatic coapod_res_t error_word(logic [2:0] code);
		coapod_res_t w;
		w = '0;
		w.status = code;
		dec_phase = DEC_IDLE;
		return w;
	endfunction

	// good word with the integer view and the block option view of the value
	function automatic coapod_res_t ok_word();
		coapod_res_t w;
		logic        fits;
		logic [31:0] v;
		int          size;
		fits = dec_len <= INT_BYTES_DEF;
		// a value too long for the integer reads as zero
		v = fits ? dec_value : 32'd0;
		size = 1 << (int'(v[2:0]) + 4);
		w = '0;
		w.status         = ST_OK;
		w.option_delta   = dec_delta;
		w.content_length = dec_len;
		w.header_bytes   = dec_hdr_cnt;
		w.int_value      = v;
		w.int_ok         = fits;
		w.block_number   = v[23:4];
		w.block_more     = v[BLOCK_MORE_BIT];
		w.block_size     = size[11:0];
		w.block_ok       = fits && (v < (32'd1 << BLOCK_VALUE_BITS)) && (size <= 1024);
		dec_phase = DEC_IDLE;
		return w;
	endfunction

	// length known: check the whole option against the budget
	function automatic bit length_done(output coapod_res_t w);
		int total;
		total = int'(dec_hdr_cnt) + int'(dec_len);
		if (total > int'(dec_budget)) begin
			w = error_word(ST_OPT_OVER);
			return 1'b1;
		end
		dec_value_left = dec_len;
		dec_value = '0;
		// empty value ends the option right at the header
		if (dec_len == 16'd0) begin
			w = ok_word();
			return 1'b1;
		end
		dec_phase = DEC_VALUE;
		return 1'b0;
	endfunction

	// delta known: look at the length nibble and the whole header size
	function automatic bit delta_done(output coapod_res_t w);
		int need;
		if (dec_lnib == NIB_RESERVED) begin
			w = error_word(ST_RESERVED);
			return 1'b1;
		end
		need = 1 + ext_bytes_for(dec_dnib) + ext_bytes_for(dec_lnib);
		if (need > int'(dec_budget)) begin
			w = error_word(ST_HDR_OVER);
			return 1'b1;
		end
		if (ext_bytes_for(dec_lnib) != 0) begin
			dec_phase = DEC_LEN_EXT;
			dec_ext_left = 2'(ext_bytes_for(dec_lnib));
			dec_len = '0;
			return 1'b0;
		end
		dec_len = 16'(dec_lnib);
		return length_done(w);
	endfunction

	// one accepted byte; returns 1 when it completes a result word
	function automatic bit decode_byte(input logic [7:0] b, input logic first,
			input logic [15:0] max_b, output coapod_res_t w);
		logic [3:0]  nib;
		logic [15:0] acc;
		logic [15:0] raw;
		w = '0;
		if (first) begin
			// a start byte always restarts, abandoning any option in progress
			dec_budget     = max_b;
			dec_dnib       = b[7:4];
			dec_lnib       = b[3:0];
			dec_hdr_cnt    = 3'd1;
			dec_delta      = '0;
			dec_len        = '0;
			dec_value      = '0;
			dec_value_left = '0;
			dec_ext_left   = '0;
			if (max_b == 16'd0) begin
				w = error_word(ST_HDR_OVER);
				return 1'b1;
			end
			if (dec_dnib == NIB_RESERVED) begin
				w = error_word(ST_RESERVED);
				return 1'b1;
			end
			if (1 + ext_bytes_for(dec_dnib) > int'(max_b)) begin
				w = error_word(ST_HDR_OVER);
				return 1'b1;
			end
			if (ext_bytes_for(dec_dnib) != 0) begin
				dec_phase = DEC_DELTA_EXT;
				dec_ext_left = 2'(ext_bytes_for(dec_dnib));
				return 1'b0;
			end
			dec_delta = 16'(dec_dnib);
			return delta_done(w);
		end
		case (dec_phase)
			DEC_DELTA_EXT, DEC_LEN_EXT: begin
				nib = (dec_phase == DEC_DELTA_EXT) ? dec_dnib : dec_lnib;
				acc = (dec_phase == DEC_DELTA_EXT) ? dec_delta : dec_len;
				dec_hdr_cnt = dec_hdr_cnt + 3'd1;
				if (nib == NIB_EXT8) begin
					acc = 16'(b) + EXT8_BASE;
				end else if (dec_ext_left == 2'd2) begin
					// high byte of a two-byte extension
					acc = {b, 8'h00};
					dec_ext_left = 2'd1;
					if (dec_phase == DEC_DELTA_EXT)
						dec_delta = acc;
					else
						dec_len = acc;
					return 1'b0;
				end else begin
					raw = {acc[15:8], b};
					if (raw > EXT16_RAW_LIMIT) begin
						w = error_word(ST_EXT_OVFL);
						return 1'b1;
					end
					acc = raw + EXT16_BASE;
				end
				dec_ext_left = '0;
				if (dec_phase == DEC_DELTA_EXT) begin
					dec_delta = acc;
					return delta_done(w);
				end
				dec_len = acc;
				return length_done(w);
			end
			DEC_VALUE: begin
				if (dec_len <= INT_BYTES_DEF)
					dec_value = {dec_value[23:0], b};
				if (dec_value_left != 16'd0)
					dec_value_left = dec_value_left - 16'd1;
				if (dec_value_left == 16'd0) begin
					w = ok_word();
					return 1'b1;
				end
				return 1'b0;
			end
			default: return 1'b0;   // idle bytes are dropped
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// sending side
	// ---------------------------------------------------------------------

	// one byte word; tvalid stays high into the next word unless a gap is drawn
	task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] max_b);
		coapod_res_t w;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {max_b, b};
		s_axis_tuser  <= first;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
		if (decode_byte(b, first, max_b, w))
			decoded_words.push_back(w);
	endtask

	// sends the first cut bytes of an option; once the parser has gone idle
	// only spare more bytes go out, and those must be dropped by the block
	task automatic send_option(input logic [7:0] opt_bytes[$], input logic [15:0] budget,
			input int cut, input int spare);
		int n;
		int left;
		n = (cut < opt_bytes.size()) ? cut : opt_bytes.size();
		left = spare;
		for (int i = 0; i < n; i++) begin
			// the budget bits only count on the start byte, so scramble them elsewhere
			send_byte(opt_bytes[i], i == 0, (i == 0) ? budget : 16'($urandom));
			if (dec_phase == DEC_IDLE) begin
				if (left == 0)
					break;
				left--;
			end
		end
	endtask

	// hold the sender until every predicted word has come out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (decoded_words.size() != 0);
	endtask

	// random option: mostly well formed, some reserved nibbles, overflowing
	// extensions, tight budgets and options cut short by the next start
	task automatic send_random_option();
		logic [7:0]  opt_bytes[$];
		logic [7:0]  dext[$];
		logic [7:0]  lext[$];
		logic [3:0]  dn;
		logic [3:0]  ln;
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [15:0] budget;
		int          pick;
		int          len;
		int          need;
		int          cut;
		len = 0;

		pick = $urandom_range(99);
		if (pick < 50) begin
			dn = 4'($urandom_range(12));
		end else if (pick < 80) begin
			dn = NIB_EXT8;
			dext.push_back(8'($urandom_range(255)));
		end else if (pick < 96) begin
			dn = NIB_EXT16;
			hi = 8'($urandom_range(254));
			lo = (hi == 8'hFE) ? 8'($urandom_range(8'hF2)) : 8'($urandom_range(255));
			dext.push_back(hi);
			dext.push_back(lo);
		end else if (pick < 98) begin
			// two-byte delta beyond the largest encodable value
			dn = NIB_EXT16;
			hi = 8'($urandom_range(255, 254));
			lo = (hi == 8'hFE) ? 8'($urandom_range(255, 8'hF3)) : 8'($urandom_range(255));
			dext.push_back(hi);
			dext.push_back(lo);
		end else begin
			dn = NIB_RESERVED;
		end

		pick = $urandom_range(99);
		if (pick < 60) begin
			ln = 4'($urandom_range(8));
			len = int'(ln);
		end else if (pick < 80) begin
			ln = 4'($urandom_range(12, 9));
			len = int'(ln);
		end else if (pick < 94) begin
			ln = NIB_EXT8;
			lo = ($urandom_range(99) < 80) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
			lext.push_back(lo);
			len = 13 + int'(lo);
		end else if (pick < 98) begin
			// two-byte length, always too long for the budget, sometimes overflowing
			ln = NIB_EXT16;
			hi = 8'($urandom_range(255));
			lo = 8'($urandom_range(255));
			lext.push_back(hi);
			lext.push_back(lo);
			len = int'({hi, lo}) + 269;
		end else begin
			ln = NIB_RESERVED;
		end

		need = 1 + dext.size() + lext.size() + len;
		pick = $urandom_range(99);
		if (pick < 70)
			budget = (need + 3 > 65535) ? 16'hFFFF : 16'(need + $urandom_range(3));
		else if (pick < 80)
			budget = 16'($urandom_range(16'hFFFF));
		else if (pick < 88)
			budget = (need > 65536) ? 16'hFFFF : 16'(need - 1);
		else if (pick < 93)
			budget = '0;
		else
			budget = 16'($urandom_range(6));
		// long values stay over budget here, the single long one has its own test
		if (len > 40 && need <= int'(budget))
			budget = 16'($urandom_range(40));

		opt_bytes.push_back({dn, ln});
		foreach (dext[i])
			opt_bytes.push_back(dext[i]);
		foreach (lext[i])
			opt_bytes.push_back(lext[i]);
		if (len <= 40)
			for (int i = 0; i < len; i++)
				opt_bytes.push_back(8'($urandom_range(255)));

		cut = WHOLE;
		if (opt_bytes.size() > 1 && $urandom_range(99) < 12)
			cut = $urandom_range(opt_bytes.size() - 1, 1);
		send_option(opt_bytes, budget, cut, $urandom_range(2));
	endtask

	// ---------------------------------------------------------------------
	// receiving side: compare each word against the oldest prediction
	// ---------------------------------------------------------------------

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
		end
	endfunction

	task automatic check_word(input coapod_res_t got);
		coapod_res_t want;
		if (decoded_words.size() == 0) begin
			mismatches++;
			$display("%0t: result word expected none actual 0x%h", $time, got);
			return;
		end
		want = decoded_words.pop_front();
		compare_field("status",         32'(want.status),         32'(got.status));
		compare_field("option_delta",   32'(want.option_delta),   32'(got.option_delta));
		compare_field("content_length", 32'(want.content_length), 32'(got.content_length));
		compare_field("header_bytes",   32'(want.header_bytes),   32'(got.header_bytes));
		compare_field("int_value",      want.int_value,           got.int_value);
		compare_field("int_ok",         32'(want.int_ok),         32'(got.int_ok));
		compare_field("block_number",   32'(want.block_number),   32'(got.block_number));
		compare_field("block_more",     32'(want.block_more),     32'(got.block_more));
		compare_field("block_size",     32'(want.block_size),     32'(got.block_size));
		compare_field("block_ok",       32'(want.block_ok),       32'(got.block_ok));
	endtask

	// values read here are the ones from before the edge, so the order of
	// processes within the step does not matter
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_word(m_axis_tdata[OUT_BITS-1:0]);
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: too long without any word moving on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// plain and extended header forms with empty values, budget extremes
	task automatic test_header_forms();
		// stray byte after reset, no option open
		send_byte(8'h5A, 1'b0, 16'hFFFF);
		send_option({8'h00}, 16'd1, WHOLE, WHOLE);
		send_option({8'hC0}, 16'hFFFF, WHOLE, WHOLE);
		// one-byte delta at its top, 268
		send_option({8'hD0, 8'hFF}, 16'd2, WHOLE, WHOLE);
		// two-byte delta at its top, 65535
		send_option({8'hE0, 8'hFE, 8'hF2}, 16'd3, WHOLE, WHOLE);
	endtask

	// every error status, and bytes after an error being dropped
	task automatic test_error_codes();
		send_option({8'h00}, 16'd0, WHOLE, WHOLE);
		send_option({8'hF0}, 16'd10, WHOLE, WHOLE);
		send_option({8'h0F}, 16'd10, WHOLE, WHOLE);
		// delta extension does not fit
		send_option({8'hD0}, 16'd1, WHOLE, WHOLE);
		// both extensions do not fit, the trailing byte must be dropped
		send_option({8'hDD, 8'h05, 8'h07}, 16'd2, WHOLE, WHOLE);
		// two-byte delta just past the limit, two-byte length far past it
		send_option({8'hE0, 8'hFE, 8'hF3}, 16'd3, WHOLE, WHOLE);
		send_option({8'h0E, 8'hFF, 8'hFF}, 16'd5, WHOLE, WHOLE);
		// value does not fit, value byte dropped
		send_option({8'h04, 8'h01}, 16'd4, WHOLE, WHOLE);
	endtask

	// integer and block views of short values, restart in the middle
	task automatic test_value_fields();
		// largest block size exponent, more flag set
		send_option({8'h11, 8'h0F}, 16'd2, WHOLE, WHOLE);
		// four-byte value above the block number range
		send_option({8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hF8}, 16'd5, WHOLE, WHOLE);
		// option left open after one of two value bytes, then a fresh start
		send_option({8'h02, 8'hAA}, 16'd3, WHOLE, WHOLE);
		send_option({8'h01, 8'h36}, 16'd2, WHOLE, WHOLE);
	endtask

	// longest header with a two-byte length and a full value behind it
	task automatic test_long_value();
		logic [7:0] opt_bytes[$];
		opt_bytes = {8'hEE, 8'h00, 8'h05, 8'h00, 8'h00};
		for (int i = 0; i < 269; i++)
			opt_bytes.push_back(8'($urandom_range(255)));
		send_option(opt_bytes, 16'd274, WHOLE, WHOLE);
	endtask

	// random traffic under three idle patterns, draining between them
	task automatic test_random_traffic();
		int stop_at;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 33;
					recv_stall_pct = 48;
				end
				1: begin
					send_idle_pct  = 48;
					recv_stall_pct = 33;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			stop_at = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < stop_at) begin
				if ($urandom_range(99) < 85) begin
					send_random_option();
				end else begin
					// loose bytes: continuations, stray starts with random budgets
					repeat ($urandom_range(4, 1))
						send_byte(8'($urandom_range(255)), $urandom_range(99) < 25,
							16'($urandom_range(16'hFFFF)));
				end
			end
			wait_for_results();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_forms();
		test_error_codes();
		test_value_fields();
		wait_for_results();
		test_long_value();
		test_random_traffic();

		// let any late or surplus word show up before the verdict
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
